[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the latency percentile block.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SWLP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SWLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SWLP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SWLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/swlp_pkg.sv]
// Types and codes of the sliding window latency percentile block.
// Depends on nothing; used by every module of the block.
package swlp_pkg;
	typedef enum logic {
		FUNC_RECORD = 1'b0,
		FUNC_QUERY  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		OP_RECORD      = 2'd0,
		OP_QUERY       = 2'd1,
		OP_QUERY_EMPTY = 2'd2
	} op_t;

	typedef struct packed {
		logic        func;
		logic [1:0]  metric;
		logic [31:0] latency_us;
	} swlp_in_t;

	typedef struct packed {
		logic [31:0] median_us;
		logic [31:0] p99_us;
		logic        empty_res;
		logic [10:0] sample_count;
	} swlp_out_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  metric;
		logic [31:0] latency_us;
	} swlp_cmd_t;

	typedef struct packed {
		logic      valid;
		swlp_cmd_t cmd;
	} swlp_queue_t;
endpackage

[rtl/swlp_front.sv]
// Front end: accepts transactions, classifies them and holds them in a two entry queue.
// Depends on swlp_pkg.
module swlp_front #(
	parameter int NUM_METRICS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  swlp_pkg::swlp_in_t   cmd,
	output logic                 busy,
	output swlp_pkg::swlp_queue_t head,
	input  logic                 pop
);
	import swlp_pkg::*;

	swlp_cmd_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       in_range;
	logic       push;
	logic       do_pop;
	swlp_cmd_t  cls;

	assign busy     = (count_q == 2'd2);
	assign in_range = (32'(cmd.metric) < NUM_METRICS);

	always_comb begin
		cls.metric     = cmd.metric;
		cls.latency_us = cmd.latency_us;
		if (cmd.func == FUNC_RECORD) begin
			cls.op = OP_RECORD;
		end else if (in_range) begin
			cls.op = OP_QUERY;
		end else begin
			cls.op = OP_QUERY_EMPTY;
		end
	end

	// An out of range record is dropped here and never reaches the back end.
	assign push   = start && !busy && (in_range || (cmd.func == FUNC_QUERY));
	assign do_pop = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(do_pop);
		end
	end
endmodule

[rtl/swlp_back.sv]
// Back end: sample store, window pointers and the bitwise rank selection engine.
// Depends on swlp_pkg.
module swlp_back #(
	parameter int WINDOW      = 1024,
	parameter int NUM_METRICS = 4,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swlp_pkg::swlp_queue_t head,
	output logic                  pop,
	output logic                  done,
	output swlp_pkg::swlp_out_t   result
);
	import swlp_pkg::*;

	localparam int MW    = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
	localparam int SW    = $clog2(WINDOW);
	localparam int CW    = $clog2(WINDOW + 1);
	localparam int DEPTH = NUM_METRICS * WINDOW;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = CW + 7;
	localparam int SH    = PW + 7;
	localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / 100);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_RANK   = 6'b000010,
		S_FIX    = 6'b000100,
		S_SCAN   = 6'b001000,
		S_DRAIN  = 6'b010000,
		S_DECIDE = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          fill_q [NUM_METRICS];
	logic [SW-1:0]          old_q  [NUM_METRICS];
	logic [SAMPLE_BITS-1:0] mem [DEPTH];
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic                   vld_s1;
	logic [AW-1:0]          mbase_q;
	logic [SW-1:0]          idx_q;
	logic [CW-1:0]          n_q;
	logic [PW-1:0]          prod_q;
	logic [PW-1:0]          qest_q;
	logic [CW-1:0]          k_q   [2];
	logic [CW-1:0]          cnt_q [2];
	logic [SAMPLE_BITS-1:0] p_q   [2];
	logic [SAMPLE_BITS-1:0] bit_q;
	logic [SAMPLE_BITS-1:0] hi_q;
	logic                   done_q;
	swlp_out_t              res_q;

	logic                   take;
	logic [MW-1:0]          mi;
	logic [CW-1:0]          fill_m;
	logic [SW-1:0]          old_m;
	logic [SW-1:0]          slot;
	logic                   we;
	logic [AW-1:0]          wa;
	logic [AW-1:0]          ra;
	logic [PW+SH-1:0]       mult;
	logic [PW-1:0]          rem;
	logic [SAMPLE_BITS-1:0] p_nxt [2];
	logic [CW-1:0]          k_nxt [2];

	assign take   = head.valid && (state_q == S_IDLE);
	assign pop    = take;
	assign mi     = MW'(head.cmd.metric);
	assign fill_m = fill_q[mi];
	assign old_m  = old_q[mi];
	// While a window is filling its oldest slot is zero, so the fill level is the slot.
	assign slot   = (32'(fill_m) < WINDOW) ? SW'(fill_m) : old_m;
	assign we     = take && (head.cmd.op == OP_RECORD);
	assign wa     = AW'(32'(mi) * WINDOW) + AW'(slot);
	assign ra     = mbase_q + AW'(idx_q);
	assign mult   = {{SH{1'b0}}, prod_q} * {{PW{1'b0}}, RECIP};
	assign rem    = prod_q - PW'(qest_q * PW'(100));

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			if (k_q[r] < cnt_q[r]) begin
				p_nxt[r] = p_q[r];
				k_nxt[r] = k_q[r];
			end else begin
				p_nxt[r] = p_q[r] | bit_q;
				k_nxt[r] = k_q[r] - cnt_q[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= SAMPLE_BITS'(head.cmd.latency_us);
		end
		rd_data_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mbase_q <= AW'(32'(mi) * WINDOW);
			n_q     <= fill_m;
			prod_q  <= PW'(fill_m) * PW'(99);
			k_q[0]  <= fill_m >> 1;
		end
		if (state_q == S_RANK) begin
			qest_q <= mult[SH +: PW];
		end
		if (state_q == S_FIX) begin
			k_q[1] <= (rem >= PW'(100)) ? CW'(qest_q + PW'(1)) : CW'(qest_q);
			p_q[0] <= '0;
			p_q[1] <= '0;
			bit_q  <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			hi_q   <= '0;
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			idx_q  <= '0;
		end
		if (state_q == S_SCAN) begin
			idx_q <= idx_q + SW'(1);
		end
		if (vld_s1) begin
			for (int r = 0; r < 2; r++) begin
				if ((((rd_data_q ^ p_q[r]) & hi_q) == '0) && ((rd_data_q & bit_q) == '0)) begin
					cnt_q[r] <= cnt_q[r] + CW'(1);
				end
			end
		end
		if (state_q == S_DECIDE) begin
			p_q[0]   <= p_nxt[0];
			p_q[1]   <= p_nxt[1];
			k_q[0]   <= k_nxt[0];
			k_q[1]   <= k_nxt[1];
			hi_q     <= hi_q | bit_q;
			bit_q    <= bit_q >> 1;
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			idx_q    <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && (head.cmd.op != OP_RECORD)) begin
			res_q <= '{median_us: 32'd0, p99_us: 32'd0, empty_res: 1'b1, sample_count: 11'd0};
		end else if ((state_q == S_DECIDE) && bit_q[0]) begin
			res_q.median_us    <= 32'(p_nxt[0]);
			res_q.p99_us       <= 32'(p_nxt[1]);
			res_q.empty_res    <= 1'b0;
			res_q.sample_count <= 11'(n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
			for (int m = 0; m < NUM_METRICS; m++) begin
				fill_q[m] <= '0;
				old_q[m]  <= '0;
			end
		end else begin
			vld_s1 <= (state_q == S_SCAN);
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						unique case (head.cmd.op)
							OP_RECORD: begin
								if (32'(fill_m) < WINDOW) begin
									fill_q[mi] <= fill_m + CW'(1);
								end else if (32'(old_m) == WINDOW - 1) begin
									old_q[mi] <= '0;
								end else begin
									old_q[mi] <= old_m + SW'(1);
								end
							end
							OP_QUERY: begin
								if (fill_m == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_RANK;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_RANK: begin
					state_q <= S_FIX;
				end
				S_FIX: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if ((CW'(idx_q) + CW'(1)) == n_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (bit_q[0]) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;
endmodule

[rtl/sliding_window_latency_percentile.sv]
// Top level of the sliding window latency percentile block.
// Depends on swlp_pkg, swlp_front, swlp_back and assert_macros.svh.
//
// A record transaction is written to the sample store as it leaves the two entry queue.
// A query of a window holding samples runs the bitwise rank search: after the rank and
// fix steps it reads the window once per result bit through the single read port of the
// sample store, then drains the read and decides the bit. An empty or out of range query
// answers from the idle state without a search once it leaves the queue. Busy is high
// while the queue is full. The result appears for exactly one cycle with done high and
// cannot be held off.
`include "assert_macros.svh"
module sliding_window_latency_percentile #(
	parameter int WINDOW      = 1024,
	parameter int NUM_METRICS = 4,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  swlp_pkg::swlp_in_t  cmd,
	output logic                busy,
	output logic                done,
	output swlp_pkg::swlp_out_t result
);
	import swlp_pkg::*;

	swlp_queue_t head;
	logic        pop;

	swlp_front #(
		.NUM_METRICS(NUM_METRICS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.head  (head),
		.pop   (pop)
	);

	swlp_back #(
		.WINDOW     (WINDOW),
		.NUM_METRICS(NUM_METRICS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.done  (done),
		.result(result)
	);

	`SWLP_ASSERT_IMPL(a_empty_zero, clk, arst_n, done && result.empty_res, (result.sample_count == 11'd0) && (result.median_us == 32'd0) && (result.p99_us == 32'd0))
	`SWLP_ASSERT_IMPL(a_full_count, clk, arst_n, done && !result.empty_res, result.sample_count != 11'd0 || WINDOW >= 2048)
	`SWLP_ASSERT_NEXT(a_pop_head, clk, arst_n, pop, !busy)
endmodule
